[rtl/assert_macros.svh]
// assertion macros shared by the magma cipher rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked check, disabled while reset is asserted
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("magma assertion failed");
// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("magma assertion failed");
`else
`define ASSERT_RST(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif
`endif

[rtl/magma_pkg.sv]
// shared types, constants, s-boxes and round function of the magma cipher
// no dependencies
package magma_pkg;

  localparam int unsigned NumRounds    = 32;
  localparam int unsigned KeyWords     = 8;
  localparam int unsigned KeyIdxW      = $clog2(KeyWords);
  localparam int unsigned CfgAddrW     = 4;
  localparam int unsigned HalfW        = 32;
  localparam int unsigned BlockW       = 2 * HalfW;
  localparam int unsigned RotLeft      = 11;
  localparam int unsigned RotRight     = 21;
  localparam int unsigned FwdRoundsEnc = 24;
  localparam int unsigned FwdRoundsDec = 8;

  localparam logic ModeEncrypt = 1'b0;
  localparam logic ModeDecrypt = 1'b1;

  typedef logic [HalfW-1:0] half_t;
  typedef half_t [KeyWords-1:0] key_sched_t;
  typedef logic [3:0] nib_t;

  typedef struct packed {
    logic  mode;
    half_t hi;
    half_t lo;
  } stage_t;

  // box n works on nibble n, box 0 on the lowest nibble
  localparam nib_t SBOX [KeyWords][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  // key add, s-box layer, rotate left
  function automatic half_t round_f(half_t half, half_t key);
    half_t sum;
    half_t sub;
    sum = half + key;
    for (int n = 0; n < KeyWords; n++) begin
      sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
    end
    return {sub[HalfW-1-RotLeft:0], sub[HalfW-1:RotRight]};
  endfunction

  // key word used by a round; the reverse run counts 7 down to 0
  function automatic logic [KeyIdxW-1:0] key_sel(int unsigned rnd, logic mode);
    int unsigned         fwd;
    logic [KeyIdxW-1:0]  idx;
    fwd = (mode == ModeDecrypt) ? FwdRoundsDec : FwdRoundsEnc;
    idx = rnd[KeyIdxW-1:0];
    if (rnd >= fwd) begin
      idx = ~idx;
    end
    return idx;
  endfunction

endpackage

[rtl/magma_key_regs.sv]
// round key register file of the magma cipher, written through the config port
// depends on magma_pkg
module magma_key_regs import magma_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  half_t               cfg_wdata_i,
  output key_sched_t          keys_o
);

  key_sched_t key_q;
  key_sched_t key_d;

  always_comb begin
    key_d = key_q;
    // indexes past the last key word are dropped
    if (cfg_we_i && (cfg_addr_i < CfgAddrW'(KeyWords))) begin
      key_d[cfg_addr_i[KeyIdxW-1:0]] = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign keys_o = key_q;

endmodule

[rtl/magma_round.sv]
// one registered feistel round of the magma cipher with its valid bit
// depends on magma_pkg
module magma_round import magma_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  stage_t data_i,
  input  half_t  key_enc_i,
  input  half_t  key_dec_i,
  output logic   valid_o,
  input  logic   ready_i,
  output stage_t data_o
);

  logic   valid_q;
  logic   valid_d;
  stage_t data_q;
  stage_t data_d;
  half_t  key;

  // stage takes a new word when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;
  assign key     = (data_i.mode == ModeDecrypt) ? key_dec_i : key_enc_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready_o) begin
      valid_d     = valid_i;
      data_d.mode = data_i.mode;
      data_d.hi   = data_i.lo;
      data_d.lo   = data_i.hi ^ round_f(data_i.lo, key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/magma_block_cipher.sv]
// Magma (GOST R 34.12-2015) 64-bit block cipher, 32 rounds fully unrolled into
// 32 register stages, one round per stage. A block is accepted every cycle in
// which the first stage has room, and its result is valid at the output from
// the last round stage, which also serves as the output register. Each stage
// holds its own valid bit and moves on when the next stage has room, so a
// stalled output only backs up as far as the pipeline is full.
// Key words are loaded through cfg_we_i/cfg_addr_i/cfg_wdata_i (index 0..7,
// others ignored) and must only change while no block is in flight.
// depends on magma_pkg, magma_key_regs, magma_round and assert_macros.svh
`include "assert_macros.svh"

module magma_block_cipher import magma_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [HalfW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [BlockW-1:0]   s_axis_tdata_i,   // [63:0] block_in
  input  logic                s_axis_tuser_i,   // [0] mode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [BlockW-1:0]   m_axis_tdata_o    // [63:0] block_out
);

  key_sched_t            keys;
  logic [NumRounds:0]    valid;
  logic [NumRounds:0]    ready;
  stage_t                data [NumRounds+1];

  magma_key_regs u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .keys_o      (keys)
  );

  assign valid[0]        = s_axis_tvalid_i;
  assign s_axis_tready_o = ready[0];
  assign data[0].mode    = s_axis_tuser_i;
  assign data[0].hi      = s_axis_tdata_i[BlockW-1:HalfW];
  assign data[0].lo      = s_axis_tdata_i[HalfW-1:0];

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    localparam logic [KeyIdxW-1:0] KeyEnc = key_sel(r, ModeEncrypt);
    localparam logic [KeyIdxW-1:0] KeyDec = key_sel(r, ModeDecrypt);

    magma_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid[r]),
      .ready_o   (ready[r]),
      .data_i    (data[r]),
      .key_enc_i (keys[KeyEnc]),
      .key_dec_i (keys[KeyDec]),
      .valid_o   (valid[r+1]),
      .ready_i   (ready[r+1]),
      .data_o    (data[r+1])
    );
  end

  // every stage swaps, so the final unswapped round is undone here
  assign ready[NumRounds] = m_axis_tready_i;
  assign m_axis_tvalid_o  = valid[NumRounds];
  assign m_axis_tdata_o   = {data[NumRounds].lo, data[NumRounds].hi};

  `ASSERT_RST(a_accept_fills_first, s_axis_tvalid_i && s_axis_tready_o |=> valid[1])
  `ASSERT_RST(a_last_feeds_out, valid[NumRounds-1] && ready[NumRounds-1] |=> m_axis_tvalid_o)
  `ASSERT_RST(a_full_stall_blocks,
              m_axis_tvalid_o && !m_axis_tready_i && (&valid[NumRounds:1]) |-> !s_axis_tready_o)

endmodule

[bench/magma_block_cipher_tb.sv]
// self-checking bench for magma_block_cipher: directed rows, then random blocks and keys
// carries its own copy of the cipher to predict each output word
// depends on magma_pkg and the magma_block_cipher rtl
module magma_block_cipher_tb;
  import magma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogCycles = 2000;
  localparam int unsigned ItemsPerPhase  = 250;
  localparam int unsigned NumPhases      = 6;
  localparam int unsigned DrainCycles    = 40;

  localparam logic [3:0] SubTab [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
    '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
      4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
    '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
      4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
    '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
      4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
    '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
      4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
    '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
      4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
    '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
      4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
  };

  typedef enum logic {RowKey, RowBlock} row_kind_e;
  typedef enum logic [1:0] {KeyStd, KeyOnes, KeyZero} key_set_e;

  typedef struct {
    row_kind_e   kind;
    key_set_e    key_set;
    logic        mode;
    logic [63:0] blk;
    bit          has_exp;
    logic [63:0] exp;
  } dir_row_t;

  localparam int unsigned DirRows = 23;

  // published test vector rows carry their expected word
  dir_row_t dir_tab [DirRows] = '{
    '{RowBlock, KeyStd, ModeEncrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeEncrypt, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeDecrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeDecrypt, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeEncrypt, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{RowKey, KeyStd, ModeEncrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeEncrypt, 64'hfedc_ba98_7654_3210, 1'b1,
      64'h4ee9_01e5_c2d8_ca3d},
    '{RowBlock, KeyStd, ModeDecrypt, 64'h4ee9_01e5_c2d8_ca3d, 1'b1,
      64'hfedc_ba98_7654_3210},
    '{RowBlock, KeyStd, ModeEncrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeEncrypt, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeDecrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeDecrypt, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeEncrypt, 64'hffff_ffff_0000_0000, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeEncrypt, 64'h0000_0000_ffff_ffff, 1'b0, 64'h0},
    '{RowBlock, KeyStd, ModeDecrypt, 64'h8000_0000_0000_0001, 1'b0, 64'h0},
    '{RowKey, KeyOnes, ModeEncrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyOnes, ModeEncrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyOnes, ModeEncrypt, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{RowBlock, KeyOnes, ModeDecrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyOnes, ModeDecrypt, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{RowKey, KeyZero, ModeEncrypt, 64'h0, 1'b0, 64'h0},
    '{RowBlock, KeyZero, ModeEncrypt, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{RowBlock, KeyZero, ModeDecrypt, 64'h5555_5555_5555_5555, 1'b0, 64'h0}
  };

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [HalfW-1:0]    cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic [BlockW-1:0]   s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_ready   = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [BlockW-1:0]   m_axis_tdata_o;

  key_sched_t        key_words = '0;
  logic [BlockW-1:0] pending_blocks [$];
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       fail_count     = 0;
  int unsigned       quiet_cycles   = 0;

  magma_block_cipher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),     // [63:0] block_in
    .s_axis_tuser_i  (s_tuser),     // [0] mode
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o) // [63:0] block_out
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // key add, nibble substitution, rotate left by 11
  function automatic logic [31:0] feistel_mix(logic [31:0] half, logic [31:0] k);
    logic [31:0] sum;
    logic [31:0] sub;
    sum = half + k;
    for (int n = 0; n < 8; n++) begin
      sub[4*n +: 4] = SubTab[n][sum[4*n +: 4]];
    end
    return {sub[20:0], sub[31:21]};
  endfunction

  function automatic logic [63:0] magma_transform(logic mode, logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] mixed;
    int unsigned fwd;
    int unsigned kidx;
    hi  = blk[63:32];
    lo  = blk[31:0];
    fwd = (mode == ModeDecrypt) ? FwdRoundsDec : FwdRoundsEnc;
    for (int unsigned r = 0; r < NumRounds; r++) begin
      kidx  = (r < fwd) ? (r % 8) : (7 - (r % 8));
      mixed = hi ^ feistel_mix(lo, key_words[kidx]);
      if (r == NumRounds - 1) begin
        hi = mixed;
      end else begin
        hi = lo;
        lo = mixed;
      end
    end
    return {hi, lo};
  endfunction

  function automatic key_sched_t key_of_set(key_set_e set);
    key_sched_t k;
    case (set)
      KeyStd: begin
        k = {32'hfcfdfeff, 32'hf8f9fafb, 32'hf4f5f6f7, 32'hf0f1f2f3,
             32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc};
      end
      KeyOnes: k = '1;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic key_sched_t random_key();
    key_sched_t k;
    for (int i = 0; i < KeyWords; i++) begin
      case ($urandom_range(5))
        0:       k[i] = '0;
        1:       k[i] = '1;
        default: k[i] = $urandom;
      endcase
    end
    return k;
  endfunction

  function automatic logic [63:0] random_block();
    logic [63:0] b;
    case ($urandom_range(9))
      0:       b = '0;
      1:       b = '1;
      2:       b = 64'd1 << $urandom_range(63);
      3:       b = ~(64'd1 << $urandom_range(63));
      4:       b = {$urandom_range(1) ? 32'hffff_ffff : 32'h0, $urandom};
      default: b = {$urandom, $urandom};
    endcase
    return b;
  endfunction

  // index writes above seven must leave the key alone
  task automatic load_key(input key_sched_t k);
    for (int i = 0; i < KeyWords; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CfgAddrW'(i);
      cfg_wdata <= k[i];
      @(posedge clk_i);
      key_words[i] = k[i];
    end
    for (int a = KeyWords; a < 2**CfgAddrW; a++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CfgAddrW'(a);
      cfg_wdata <= $urandom;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_block(input logic mode, input logic [63:0] blk,
                            input logic [63:0] want);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= blk;
    s_tuser <= mode;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end
    pending_blocks.push_back(want);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // outputs and ready are sampled mid-cycle, when they hold the value of the next edge
  always @(negedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_blocks.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata_o);
      end else begin
        want = pending_blocks.pop_front();
        if (m_axis_tdata_o !== want) begin
          fail_count++;
          $display("%0t: block_out mismatch, expected %h, actual %h",
                   $time, want, m_axis_tdata_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogCycles) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time, pending_blocks.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] b;
    logic [63:0] c;
    logic        md;
    int unsigned sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowKey) begin
        wait_drained();
        load_key(key_of_set(dir_tab[i].key_set));
      end else begin
        send_block(dir_tab[i].mode, dir_tab[i].blk,
                   dir_tab[i].has_exp ? dir_tab[i].exp
                                      : magma_transform(dir_tab[i].mode, dir_tab[i].blk));
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      load_key(random_key());
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if (p == 0 && sent >= ItemsPerPhase / 2 && sent < ItemsPerPhase / 2 + 2) begin
          wait_drained();
        end
        b  = random_block();
        md = 1'($urandom_range(1));
        case ($urandom_range(4))
          0: begin
            // round trip: encrypt, then decrypt the predicted ciphertext
            c = magma_transform(ModeEncrypt, b);
            send_block(ModeEncrypt, b, c);
            send_block(ModeDecrypt, c, magma_transform(ModeDecrypt, c));
            sent += 2;
          end
          1: begin
            send_block(ModeEncrypt, b, magma_transform(ModeEncrypt, b));
            send_block(ModeDecrypt, b, magma_transform(ModeDecrypt, b));
            sent += 2;
          end
          default: begin
            send_block(md, b, magma_transform(md, b));
            sent++;
          end
        endcase
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
